// File: hdl/url_percent_decoder_defines.svh
// Assertion macros for the URL percent decoder.
// Both expect signals clk and arst_n in the scope where they are used.
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define UPD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("url_percent_decoder: assertion failed");

// Check that cons holds in the cycle after ante.
`define UPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("url_percent_decoder: assertion failed");

`endif

// File: hdl/upd_pkg.sv
package upd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DIG_0   = 8'h30;
	localparam logic [7:0] CH_DIG_9   = 8'h39;
	localparam logic [7:0] CH_LOW_A   = 8'h61;
	localparam logic [7:0] CH_LOW_F   = 8'h66;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_F    = 8'h46;
	localparam logic [3:0] HEX_TEN    = 4'd10;

	localparam logic [15:0] MAX_BYTES_RESET = 16'd1024;
	localparam logic [15:0] COUNT_SAT       = 16'hFFFF;

	// Escape phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;

	typedef struct packed {
		logic [7:0] in_char;
		logic       is_last;
	} item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        done_res;
		logic        status;
		logic [15:0] byte_count;
	} res_t;

	typedef struct packed {
		logic present;
		res_t res;
	} step_res_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nibble;
	} hex_t;

	function automatic hex_t hex_value(logic [7:0] c);
		hex_t       h;
		logic [7:0] d;
		h = '0;
		d = '0;
		if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
			d = c - CH_DIG_0;
			h.ok = 1'b1;
			h.nibble = d[3:0];
		end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
			d = c - CH_LOW_A;
			h.ok = 1'b1;
			h.nibble = d[3:0] + HEX_TEN;
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			d = c - CH_UP_A;
			h.ok = 1'b1;
			h.nibble = d[3:0] + HEX_TEN;
		end
		return h;
	endfunction

endpackage

// File: hdl/upd_in_reg.sv
module upd_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_char,
	input  logic                is_last,
	input  logic                advance,
	output logic                item_valid,
	output upd_pkg::item_t      item
);

	logic           valid_s1;
	upd_pkg::item_t item_s1;

	// take a new word whenever none is held or the held one leaves this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.in_char <= in_char;
			item_s1.is_last <= is_last;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// File: hdl/upd_core.sv
module upd_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  upd_pkg::item_t       item,
	input  logic [15:0]          max_bytes,
	output upd_pkg::step_res_t   step
);

	logic [1:0]  phase_q;
	logic [7:0]  acc_q;
	logic [15:0] count_q;
	logic        halted_q;
	logic        err_q;

	logic [1:0]  phase_n;
	logic [7:0]  acc_n;
	logic [15:0] count_n;
	logic        halted_n;
	logic        err_n;
	logic        emit;
	logic [7:0]  byte_v;
	upd_pkg::hex_t hex;

	always_comb begin
		hex      = upd_pkg::hex_value(item.in_char);
		phase_n  = phase_q;
		acc_n    = acc_q;
		halted_n = halted_q;
		err_n    = err_q;
		emit     = 1'b0;
		byte_v   = '0;

		if (!err_q && !halted_q) begin
			if (phase_q == upd_pkg::PH_HIGH || phase_q == upd_pkg::PH_LOW) begin
				if (!hex.ok) begin
					err_n   = 1'b1;
					phase_n = upd_pkg::PH_IDLE;
				end else begin
					acc_n = {acc_q[3:0], hex.nibble};
					if (phase_q == upd_pkg::PH_HIGH) begin
						phase_n = upd_pkg::PH_LOW;
					end else begin
						byte_v  = acc_n;
						emit    = 1'b1;
						phase_n = upd_pkg::PH_IDLE;
					end
				end
			end else begin
				// limit is checked only where a new sequence starts
				phase_n = upd_pkg::PH_IDLE;
				if (count_q >= max_bytes) begin
					halted_n = 1'b1;
				end else if (item.in_char == upd_pkg::CH_PERCENT) begin
					phase_n = upd_pkg::PH_HIGH;
					acc_n   = '0;
				end else if (item.in_char == upd_pkg::CH_PLUS) begin
					byte_v = upd_pkg::CH_SPACE;
					emit   = 1'b1;
				end else begin
					byte_v = item.in_char;
					emit   = 1'b1;
				end
			end
		end

		// flush an unfinished escape at the end of the string
		if (item.is_last && !err_n &&
		    (phase_n == upd_pkg::PH_HIGH || phase_n == upd_pkg::PH_LOW)) begin
			byte_v  = acc_n;
			emit    = 1'b1;
			phase_n = upd_pkg::PH_IDLE;
		end

		count_n = (emit && count_q != upd_pkg::COUNT_SAT) ? count_q + 16'd1 : count_q;

		step.present        = emit || item.is_last;
		step.res.out_byte   = emit ? byte_v : 8'd0;
		step.res.byte_valid = emit;
		step.res.done_res   = item.is_last;
		step.res.status     = item.is_last && err_n;
		step.res.byte_count = (item.is_last && !err_n) ? count_n : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= upd_pkg::PH_IDLE;
			acc_q    <= '0;
			count_q  <= '0;
			halted_q <= 1'b0;
			err_q    <= 1'b0;
		end else if (advance) begin
			if (item.is_last) begin
				phase_q  <= upd_pkg::PH_IDLE;
				acc_q    <= '0;
				count_q  <= '0;
				halted_q <= 1'b0;
				err_q    <= 1'b0;
			end else begin
				phase_q  <= phase_n;
				acc_q    <= acc_n;
				count_q  <= count_n;
				halted_q <= halted_n;
				err_q    <= err_n;
			end
		end
	end

endmodule

// File: hdl/url_percent_decoder.sv
// Streaming URL percent decoder. Feed one character per input word with
// is_last on the final character of a string; '%hh' (either case) becomes one
// byte, '+' becomes a space and everything else passes through. A bad escape
// makes the done word report status 1 and byte_count 0; bytes already sent
// stay sent. Once max_output_bytes (cfg_wdata, written by cfg_we, reset 1024)
// bytes are out, later characters are dropped until is_last. A non-last word
// yields an output word only when it completes a byte; the last word always
// yields one, carrying done_res, status and byte_count. Throughput is one word
// per cycle unless the output stalls: the per-string state (escape phase,
// nibble, count, flags) is updated by one short step between the input and
// output registers. An accepted word waits in the input register until the
// output register is free or draining, then loads it if it yields output.
// Only output backpressure stalls the input; write the limit only while idle.
`include "url_percent_decoder_defines.svh"

module url_percent_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_char,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        done_res,
	output logic        status,
	output logic [15:0] byte_count,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic               item_valid;
	upd_pkg::item_t     item;
	upd_pkg::step_res_t step;
	logic               advance;
	logic               load;
	logic [15:0]        max_q;
	logic               valid_s2;
	upd_pkg::res_t      res_s2;

	// advance the held character when the output stage is free or draining
	assign advance = item_valid && (!valid_s2 || out_ready);
	assign load    = advance && step.present;

	upd_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_char    (in_char),
		.is_last    (is_last),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	upd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item),
		.max_bytes (max_q),
		.step      (step)
	);

	// byte limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= upd_pkg::MAX_BYTES_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// output register: hold until taken, refill in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= step.res;
		end
	end

	assign out_valid  = valid_s2;
	assign out_byte   = res_s2.out_byte;
	assign byte_valid = res_s2.byte_valid;
	assign done_res   = res_s2.done_res;
	assign status     = res_s2.status;
	assign byte_count = res_s2.byte_count;

	// a failed string reports no bytes
	`UPD_ASSERT_SAME(a_err_zero_count, out_valid && done_res && status, byte_count == 16'd0)
	// a word without done always carries a byte
	`UPD_ASSERT_SAME(a_mid_has_byte, out_valid && !done_res, byte_valid)
	// status is only ever reported on the done word
	`UPD_ASSERT_SAME(a_status_done, out_valid && status, done_res)
	// the input stalls only behind a stalled output word
	`UPD_ASSERT_SAME(a_stall_cause, item_valid && !in_ready, out_valid && !out_ready)

endmodule
